@@ hw/rtl/lbia_pkg.sv @@
// Package for the linear bound interval accumulator.
// Holds channel payload types, relation codes, limit constants and control types.
// Depends on nothing; lbia_if, lbia_front, lbia_back and the top level use it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package lbia_pkg;

  typedef enum logic [1:0] {
    REL_LE = 2'd0,
    REL_LT = 2'd1,
    REL_GE = 2'd2,
    REL_GT = 2'd3
  } rel_t;

  localparam logic [1:0] OFS_ADD = 2'd1;
  localparam logic [1:0] OFS_SUB = 2'd2;

  localparam logic [1:0] TRUTH_FALSE = 2'd0;
  localparam logic [1:0] TRUTH_TRUE  = 2'd1;

  localparam logic signed [31:0] BOUND_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] BOUND_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic               first_constraint;
    logic [1:0]         atom_truth;
    logic signed [15:0] coefficient;
    logic [1:0]         offset_mode;
    logic signed [15:0] inner_offset;
    logic [1:0]         relation;
    logic signed [15:0] bound_constant;
  } item_t;

  typedef struct packed {
    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;
    logic               consistent;
    logic               zero_coefficient;
  } result_t;

  // Classification of one item, passed from the front end to the back end.
  typedef struct packed {
    logic restart;
    logic apply;
    logic zero;
    logic upper;
  } ctrl_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_FIX,
    BK_CLIP,
    BK_POST
  } back_state_t;

  // Logical negation of a relation: not (x <= b) is x > b, and so on.
  function automatic rel_t negate_rel(input rel_t r);
    rel_t res;
    unique case (r)
      REL_LE:  res = REL_GT;
      REL_LT:  res = REL_GE;
      REL_GE:  res = REL_LT;
      default: res = REL_LE;
    endcase
    return res;
  endfunction

  // Direction swap when both sides are multiplied by -1.
  function automatic rel_t mirror_rel(input rel_t r);
    rel_t res;
    unique case (r)
      REL_LE:  res = REL_GE;
      REL_LT:  res = REL_GT;
      REL_GE:  res = REL_LE;
      default: res = REL_LT;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lbia_if.sv @@
// Valid/ready channel interfaces of the linear bound interval accumulator.
// Depends on lbia_pkg for the item and result payload types.
`timescale 1ns / 1ps
`default_nettype none

interface lbia_item_if;
  logic                valid;
  logic                ready;
  lbia_pkg::item_t     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lbia_result_if;
  logic                valid;
  logic                ready;
  lbia_pkg::result_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lbia_front.sv @@
// Front end: takes constraint items and reduces each to a division job.
// Depends on lbia_pkg and lbia_if.
`timescale 1ns / 1ps
`default_nettype none

module lbia_front #(
  parameter int OPERAND_WIDTH = 16
) (
  lbia_item_if.sink                         items,
  output logic                              push_valid,
  input  logic                              push_ready,
  output lbia_pkg::ctrl_t                   push_ctrl,
  output logic signed [OPERAND_WIDTH+2:0]   push_num,
  output logic        [OPERAND_WIDTH-1:0]   push_div
);

  localparam int NUM_WIDTH = OPERAND_WIDTH + 3;

  logic signed [OPERAND_WIDTH-1:0] coef;
  logic signed [OPERAND_WIDTH-1:0] ofs;
  logic signed [OPERAND_WIDTH-1:0] rhs_const;
  logic signed [NUM_WIDTH-1:0]     rhs;
  logic signed [NUM_WIDTH-1:0]     rhs_dir;
  lbia_pkg::rel_t                  rel_in;
  lbia_pkg::rel_t                  rel_pol;
  lbia_pkg::rel_t                  rel_dir;
  logic                            neg;
  logic                            defined;

  assign push_valid  = items.valid;
  assign items.ready = push_ready;

  always_comb begin
    // Operands wrap to the operand width, two's complement.
    coef      = OPERAND_WIDTH'(items.data.coefficient);
    ofs       = OPERAND_WIDTH'(items.data.inner_offset);
    rhs_const = OPERAND_WIDTH'(items.data.bound_constant);

    // Move the inner offset to the right-hand side.
    case (items.data.offset_mode)
      lbia_pkg::OFS_ADD: rhs = NUM_WIDTH'(rhs_const) - NUM_WIDTH'(ofs);
      lbia_pkg::OFS_SUB: rhs = NUM_WIDTH'(rhs_const) + NUM_WIDTH'(ofs);
      default:           rhs = NUM_WIDTH'(rhs_const);
    endcase

    rel_in  = lbia_pkg::rel_t'(items.data.relation);
    rel_pol = (items.data.atom_truth == lbia_pkg::TRUTH_FALSE) ?
              lbia_pkg::negate_rel(rel_in) : rel_in;

    // A negative coefficient flips both sides and the relation.
    neg     = coef[OPERAND_WIDTH-1];
    rel_dir = neg ? lbia_pkg::mirror_rel(rel_pol) : rel_pol;
    rhs_dir = neg ? -rhs : rhs;
    push_div = neg ? $unsigned(-coef) : $unsigned(coef);

    // Strict relations become inclusive on the integers.
    case (rel_dir)
      lbia_pkg::REL_LT: push_num = rhs_dir - NUM_WIDTH'(1);
      lbia_pkg::REL_GT: push_num = rhs_dir + NUM_WIDTH'(1);
      default:          push_num = rhs_dir;
    endcase

    defined = (items.data.atom_truth == lbia_pkg::TRUTH_FALSE) ||
              (items.data.atom_truth == lbia_pkg::TRUTH_TRUE);

    push_ctrl.restart = items.data.first_constraint;
    push_ctrl.zero    = (coef == '0);
    push_ctrl.apply   = defined && (coef != '0);
    push_ctrl.upper   = (rel_dir == lbia_pkg::REL_LE) || (rel_dir == lbia_pkg::REL_LT);
  end

endmodule

`default_nettype wire

@@ hw/rtl/lbia_queue.sv @@
// Small register queue that decouples the front end from the back end.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module lbia_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue occupancy beyond its depth");

endmodule

`default_nettype wire

@@ hw/rtl/lbia_back.sv @@
// Back end: iterative floor/ceil divider, limit update and result register.
// Depends on lbia_pkg and lbia_if.
`timescale 1ns / 1ps
`default_nettype none

module lbia_back #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  lbia_pkg::ctrl_t                   pop_ctrl,
  input  logic signed [OPERAND_WIDTH+2:0]   pop_num,
  input  logic        [OPERAND_WIDTH-1:0]   pop_div,
  lbia_result_if.source                     bounds
);

  localparam int NUM_WIDTH = OPERAND_WIDTH + 3;
  localparam int QS_WIDTH  = NUM_WIDTH + 1;
  localparam int CMP_WIDTH = (QS_WIDTH > 33) ? QS_WIDTH : 33;
  localparam int CNT_W     = $clog2(NUM_WIDTH + 1);

  lbia_pkg::back_state_t           state;
  lbia_pkg::back_state_t           state_next;
  lbia_pkg::ctrl_t                 ctrl;
  logic        [NUM_WIDTH-1:0]     dvd;
  logic                            negative;
  logic        [OPERAND_WIDTH-1:0] divisor;
  logic        [OPERAND_WIDTH:0]   rem;
  logic        [CNT_W-1:0]         cnt;
  logic signed [QS_WIDTH-1:0]      qsig;
  logic signed [31:0]              lim;
  logic signed [31:0]              low_limit;
  logic signed [31:0]              high_limit;
  logic                            out_valid;
  lbia_pkg::result_t               out_data;

  logic                            take;
  logic                            out_free;
  logic        [OPERAND_WIDTH:0]   rem_sh;
  logic        [OPERAND_WIDTH+1:0] diff;
  logic        [NUM_WIDTH-1:0]     num_mag;
  logic signed [QS_WIDTH-1:0]      q_base;
  logic signed [CMP_WIDTH-1:0]     q_ext;
  logic signed [31:0]              low_next;
  logic signed [31:0]              high_next;

  assign bounds.valid = out_valid;
  assign bounds.data  = out_data;
  assign out_free     = !out_valid || bounds.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lbia_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop_ready  = 1'b0;
    unique case (state)
      lbia_pkg::BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          state_next = pop_ctrl.apply ? lbia_pkg::BK_DIV : lbia_pkg::BK_POST;
        end
      end
      lbia_pkg::BK_DIV: begin
        if (cnt == CNT_W'(1)) begin
          state_next = lbia_pkg::BK_FIX;
        end
      end
      lbia_pkg::BK_FIX:  state_next = lbia_pkg::BK_CLIP;
      lbia_pkg::BK_CLIP: state_next = lbia_pkg::BK_POST;
      lbia_pkg::BK_POST: begin
        if (out_free) begin
          state_next = lbia_pkg::BK_IDLE;
        end
      end
      default: state_next = lbia_pkg::BK_IDLE;
    endcase
  end

  // Datapath arithmetic.
  always_comb begin
    num_mag = pop_num[NUM_WIDTH-1] ? $unsigned(-pop_num) : $unsigned(pop_num);

    // One restoring step per cycle.
    rem_sh = {rem[OPERAND_WIDTH-1:0], dvd[NUM_WIDTH-1]};
    diff   = {1'b0, rem_sh} - {2'b00, divisor};

    // Truncated quotient with its sign, before rounding toward the kept bound.
    q_base = negative ? -$signed({1'b0, dvd}) : $signed({1'b0, dvd});

    q_ext = CMP_WIDTH'(qsig);

    low_next  = ctrl.restart ? lbia_pkg::BOUND_MIN : low_limit;
    high_next = ctrl.restart ? lbia_pkg::BOUND_MAX : high_limit;
    if (ctrl.apply) begin
      if (ctrl.upper) begin
        if (lim < high_next) begin
          high_next = lim;
        end
      end else begin
        if (lim > low_next) begin
          low_next = lim;
        end
      end
    end
  end

  assign take = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    case (state)
      lbia_pkg::BK_IDLE: begin
        if (take) begin
          ctrl     <= pop_ctrl;
          dvd      <= num_mag;
          negative <= pop_num[NUM_WIDTH-1];
          divisor  <= pop_div;
          rem      <= '0;
          cnt      <= CNT_W'(NUM_WIDTH);
        end
      end
      lbia_pkg::BK_DIV: begin
        if (!diff[OPERAND_WIDTH+1]) begin
          rem <= diff[OPERAND_WIDTH:0];
        end else begin
          rem <= rem_sh;
        end
        dvd <= {dvd[NUM_WIDTH-2:0], !diff[OPERAND_WIDTH+1]};
        cnt <= cnt - 1'b1;
      end
      lbia_pkg::BK_FIX: begin
        // Floor for an upper bound, ceiling for a lower bound.
        if (ctrl.upper) begin
          qsig <= q_base - QS_WIDTH'(negative && (rem != '0));
        end else begin
          qsig <= q_base + QS_WIDTH'(!negative && (rem != '0));
        end
      end
      lbia_pkg::BK_CLIP: begin
        if (q_ext < CMP_WIDTH'(lbia_pkg::BOUND_MIN)) begin
          lim <= lbia_pkg::BOUND_MIN;
        end else if (q_ext > CMP_WIDTH'(lbia_pkg::BOUND_MAX)) begin
          lim <= lbia_pkg::BOUND_MAX;
        end else begin
          lim <= 32'(q_ext);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit  <= lbia_pkg::BOUND_MIN;
      high_limit <= lbia_pkg::BOUND_MAX;
      out_valid  <= 1'b0;
    end else begin
      if (state == lbia_pkg::BK_POST && out_free) begin
        low_limit  <= low_next;
        high_limit <= high_next;
        out_valid  <= 1'b1;
      end else if (bounds.ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == lbia_pkg::BK_POST && out_free) begin
      out_data.lower_bound      <= low_next;
      out_data.upper_bound      <= high_next;
      out_data.consistent       <= (low_next <= high_next);
      out_data.zero_coefficient <= ctrl.zero;
    end
  end

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    state == lbia_pkg::BK_DIV |-> rem < {1'b0, divisor})
    else $error("divider remainder not below divisor");

  a_limits_hold: assert property (@(posedge clk) disable iff (rst)
    state != lbia_pkg::BK_POST |=> $stable(low_limit) && $stable(high_limit))
    else $error("limits changed outside the update step");

  a_consistent_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.consistent == (out_data.lower_bound <= out_data.upper_bound))
    else $error("consistent flag disagrees with reported bounds");

  a_pop_starts_job: assert property (@(posedge clk) disable iff (rst)
    take |=> (state == lbia_pkg::BK_DIV) || (state == lbia_pkg::BK_POST))
    else $error("taken item did not start a job");

endmodule

`default_nettype wire

@@ hw/rtl/linear_bound_interval_accumulator.sv @@
// Top level of the linear bound interval accumulator.
// Depends on lbia_pkg, lbia_if, lbia_front, lbia_queue and lbia_back.
//
// Usage: constraint items a*x (+/- k) REL b arrive on the items channel,
// each with the truth value of its guarding atom. Every item produces
// exactly one transfer on the bounds channel carrying the current lower
// and upper limit of x, whether the interval is non-empty, and whether the
// item was skipped for a zero coefficient. Both channels use valid/ready;
// a transfer happens at a rising edge with valid and ready both high.
//
// Processing: an item that needs a division runs through the restoring
// divider in the back end, which retires one quotient bit per cycle over
// OPERAND_WIDTH + 3 bits, then through rounding, clamping and update steps.
// Items that are ignored or skipped go straight to the update step. Items
// are processed one at a time; a two-entry queue lets the items channel
// keep accepting while a division runs.
//
// Reset (rst, synchronous) empties the queue, drops any pending result and
// sets the interval to unbounded. If the receiver stalls, the result stays
// in the output register, the back end holds its next result, and once the
// queue fills, items.ready falls.
`timescale 1ns / 1ps
`default_nettype none

module linear_bound_interval_accumulator #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  lbia_item_if.sink     items,
  lbia_result_if.source bounds
);

  localparam int NUM_WIDTH   = OPERAND_WIDTH + 3;
  localparam int ENTRY_WIDTH = $bits(lbia_pkg::ctrl_t) + NUM_WIDTH + OPERAND_WIDTH;
  localparam int QUEUE_DEPTH = 2;

  // Front end to queue.
  logic                            push_valid;
  logic                            push_ready;
  lbia_pkg::ctrl_t                 push_ctrl;
  logic signed [NUM_WIDTH-1:0]     push_num;
  logic        [OPERAND_WIDTH-1:0] push_div;

  // Queue to back end.
  logic                            pop_valid;
  logic                            pop_ready;
  logic        [ENTRY_WIDTH-1:0]   pop_data;
  lbia_pkg::ctrl_t                 pop_ctrl;
  logic signed [NUM_WIDTH-1:0]     pop_num;
  logic        [OPERAND_WIDTH-1:0] pop_div;

  // The front end folds offset, atom polarity, coefficient sign and
  // strictness into one numerator, a positive divisor and a bound side.
  lbia_front #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_front (
    .items      (items),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_ctrl  (push_ctrl),
    .push_num   (push_num),
    .push_div   (push_div)
  );

  lbia_queue #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_ctrl, push_num, push_div}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign {pop_ctrl, pop_num, pop_div} = pop_data;

  // The back end divides, rounds toward the kept bound, clamps to 32 bits,
  // applies any restart and tightens the limits in item order.
  lbia_back #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_ctrl  (pop_ctrl),
    .pop_num   (pop_num),
    .pop_div   (pop_div),
    .bounds    (bounds)
  );

endmodule

`default_nettype wire
